>>> design/ptp_pkg.sv
// ptp_pkg: shared constants, codes and control types for the perceptron block
// no dependencies; imported by ptp_mul_unit, ptp_ctrl, perceptron_train_predict and tb
package ptp_pkg;

    localparam int MAX_FEATURES = 8;

    localparam int POS_W  = $clog2(MAX_FEATURES + 1);
    localparam int IDX_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 33;
    localparam int PROD_W = MUL_A_W + MUL_B_W;
    localparam int ACC_W  = PROD_W + $clog2(MAX_FEATURES + 1);
    localparam logic [15:0] ETA_RESET = 16'd655;
    localparam logic [15:0] ERR_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_PREDICT = 2'd0,
        KIND_TRAIN   = 2'd1,
        KIND_EPOCH   = 2'd2,
        KIND_CLEAR   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_DECIDE,
        ST_REPORT,
        ST_UPD_MUL,
        ST_UPD_ADD,
        ST_UPD_BIAS
    } state_t;

    typedef struct packed {
        logic  in_valid;
        logic  in_last;
        kind_t kind;
        logic  pos_full;
        logic  pos_zero;
        logic  last_held;
        logic  out_free;
        logic  train_err;
        logic  upd_done;
    } status_t;

    typedef struct packed {
        logic in_ready;
        logic buf_write;
        logic mul_acc;
        logic acc_add;
        logic emit_pred;
        logic emit_report;
        logic start_update;
        logic mul_upd;
        logic weight_add;
        logic bias_add;
        logic vec_clear;
        logic weights_clear;
    } ctrl_t;

endpackage

>>> design/ptp_mul_unit.sv
// ptp_mul_unit: shared signed multiplier with registered product
// depends on ptp_pkg for operand and product widths
module ptp_mul_unit (
    input  logic                                 clk,
    input  logic                                 load,
    input  logic signed [ptp_pkg::MUL_A_W-1:0]   a,
    input  logic signed [ptp_pkg::MUL_B_W-1:0]   b,
    output logic signed [ptp_pkg::PROD_W-1:0]    prod
);
    import ptp_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    always_comb
    begin
        prod_next = prod_reg;
        if (load)
        begin
            prod_next = a * b;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

>>> design/ptp_ctrl.sv
// ptp_ctrl: sequencer for feature accumulation, decision and weight update
// depends on ptp_pkg for state, status and control types
module ptp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  ptp_pkg::status_t  status,
    output ptp_pkg::ctrl_t    ctl
);
    import ptp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.in_valid)
                begin
                    case (status.kind)
                        KIND_EPOCH:
                        begin
                            state_next = ST_REPORT;
                        end
                        KIND_CLEAR:
                        begin
                            state_next = ST_IDLE;
                        end
                        default:
                        begin
                            if (!status.pos_full)
                            begin
                                state_next = ST_ACC;
                            end
                            else if (status.in_last)
                            begin
                                state_next = ST_DECIDE;
                            end
                        end
                    endcase
                end
            end
            ST_ACC:
            begin
                state_next = status.last_held ? ST_DECIDE : ST_IDLE;
            end
            ST_DECIDE:
            begin
                if (status.out_free)
                begin
                    if (!status.train_err)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (status.pos_zero)
                    begin
                        state_next = ST_UPD_BIAS;
                    end
                    else
                    begin
                        state_next = ST_UPD_MUL;
                    end
                end
            end
            ST_REPORT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_UPD_MUL:
            begin
                state_next = ST_UPD_ADD;
            end
            ST_UPD_ADD:
            begin
                state_next = status.upd_done ? ST_UPD_BIAS : ST_UPD_MUL;
            end
            ST_UPD_BIAS:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        ctl = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctl.in_ready = 1'b1;
                if (status.in_valid)
                begin
                    case (status.kind)
                        KIND_EPOCH:
                        begin
                            ctl.vec_clear = 1'b0;
                        end
                        KIND_CLEAR:
                        begin
                            ctl.weights_clear = 1'b1;
                            ctl.vec_clear     = 1'b1;
                        end
                        default:
                        begin
                            if (!status.pos_full)
                            begin
                                ctl.buf_write = 1'b1;
                                ctl.mul_acc   = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_ACC:
            begin
                ctl.acc_add = 1'b1;
            end
            ST_DECIDE:
            begin
                if (status.out_free)
                begin
                    ctl.emit_pred = 1'b1;
                    if (status.train_err)
                    begin
                        ctl.start_update = 1'b1;
                    end
                    else
                    begin
                        ctl.vec_clear = 1'b1;
                    end
                end
            end
            ST_REPORT:
            begin
                ctl.emit_report = status.out_free;
            end
            ST_UPD_MUL:
            begin
                ctl.mul_upd = 1'b1;
            end
            ST_UPD_ADD:
            begin
                ctl.weight_add = 1'b1;
            end
            ST_UPD_BIAS:
            begin
                ctl.bias_add  = 1'b1;
                ctl.vec_clear = 1'b1;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

>>> design/perceptron_train_predict.sv
// perceptron_train_predict: fixed-point perceptron with learning-rule update
// depends on ptp_pkg, ptp_mul_unit and ptp_ctrl
//
// A feature transfer (kind 0 or 1) forms feature times weight in the shared 17x33
// multiplier in the accept cycle, and the next cycle adds it to the net input. A feature
// beyond the buffer is dropped. The closing feature then passes through a decision state,
// which waits while the output register still holds an untaken result. A training vector
// that mispredicts at nonzero eta then runs a multiplier step and a round and saturating
// add step for each buffered feature, then a bias step, on its last transfer. An epoch
// close passes through a report state, and a clear completes in its accept cycle. The
// block is not ready while an item is in work; results leave through an output register.
module perceptron_train_predict (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [15:0] feature_value,
    input  logic        label,
    input  logic        last_feature,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        prediction,
    output logic [15:0] error_count,
    output logic        is_epoch_report
);
    import ptp_pkg::*;

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111)
        begin
            r = v[31:0];
        end
        else if (v[33])
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

    status_t status;
    ctrl_t   ctl;

    logic [15:0]              learning_rate_reg;
    logic signed [31:0]       weights_reg [MAX_FEATURES+1];
    logic signed [15:0]       feature_buffer_reg [MAX_FEATURES];
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         pos_next;
    logic [POS_W-1:0]         upd_idx_reg;
    logic [POS_W-1:0]         upd_idx_next;
    logic [15:0]              errors_reg;
    logic [15:0]              errors_next;
    kind_t                    kind_reg;
    logic                     label_reg;
    logic                     last_reg;
    logic                     pred_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     prediction_reg;
    logic [15:0]              error_count_reg;
    logic                     is_epoch_report_reg;

    logic                      in_fire;
    logic [POS_W-1:0]          w_rd_addr;
    logic signed [31:0]        w_rd;
    logic signed [31:0]        w0;
    logic signed [15:0]        buf_rd;
    logic signed [MUL_A_W-1:0] buf_ext;
    logic signed [MUL_A_W-1:0] buf_mag;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   net;
    logic                      pred_now;
    logic [31:0]               rnd;
    logic signed [33:0]        w_ext;
    logic signed [33:0]        r_ext;
    logic signed [33:0]        w_sum;
    logic signed [33:0]        w0_ext;
    logic signed [33:0]        eta_ext;
    logic signed [33:0]        b_sum;
    logic                      delta_neg;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && ctl.in_ready;
    assign in_ready  = ctl.in_ready;

    // sequencer
    assign status.in_valid  = in_valid;
    assign status.in_last   = last_feature;
    assign status.kind      = kind_t'(kind);
    assign status.pos_full  = (pos_reg >= POS_W'(MAX_FEATURES));
    assign status.pos_zero  = (pos_reg == '0);
    assign status.last_held = last_reg;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.train_err = (kind_reg == KIND_TRAIN) && (label_reg != pred_now)
                              && (learning_rate_reg != '0);
    assign status.upd_done  = ((upd_idx_reg + POS_W'(1)) == pos_reg);

    ptp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctl    (ctl)
    );

    // operand selection for the shared multiplier
    assign w_rd_addr = ctl.mul_acc ? (pos_reg + POS_W'(1)) : (upd_idx_reg + POS_W'(1));
    assign w_rd      = weights_reg[w_rd_addr];
    assign w0        = weights_reg[0];
    assign buf_rd    = feature_buffer_reg[upd_idx_reg[IDX_W-1:0]];
    assign buf_ext   = {buf_rd[15], buf_rd};
    assign buf_mag   = buf_rd[15] ? -buf_ext : buf_ext;

    assign mul_a = ctl.mul_acc ? {feature_value[15], feature_value} : buf_mag;
    assign mul_b = ctl.mul_acc ? {w_rd[31], w_rd} : {17'd0, learning_rate_reg};

    ptp_mul_unit u_mul (
        .clk  (clk),
        .load (ctl.mul_acc || ctl.mul_upd),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // decision
    assign net      = acc_reg + {{(ACC_W-40){w0[31]}}, w0, 8'd0};
    assign pred_now = !net[ACC_W-1] && (net != '0);

    // weight update: round |eta*x| from Q.24 to Q.16, then apply the sign
    assign rnd       = prod[31:0] + 32'd128;
    assign delta_neg = buf_rd[15] ^ pred_reg;
    assign w_ext     = {{2{w_rd[31]}}, w_rd};
    assign r_ext     = {10'd0, rnd[31:8]};
    assign w_sum     = delta_neg ? (w_ext - r_ext) : (w_ext + r_ext);
    assign w0_ext    = {{2{w0[31]}}, w0};
    assign eta_ext   = {18'd0, learning_rate_reg};
    assign b_sum     = pred_reg ? (w0_ext - eta_ext) : (w0_ext + eta_ext);

    always_comb
    begin
        acc_next     = acc_reg;
        pos_next     = pos_reg;
        upd_idx_next = upd_idx_reg;
        errors_next  = errors_reg;
        if (ctl.acc_add)
        begin
            acc_next = acc_reg + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
            pos_next = pos_reg + POS_W'(1);
        end
        if (ctl.vec_clear)
        begin
            acc_next = '0;
            pos_next = '0;
        end
        if (ctl.start_update)
        begin
            upd_idx_next = '0;
        end
        else if (ctl.weight_add)
        begin
            upd_idx_next = upd_idx_reg + POS_W'(1);
        end
        if (ctl.weights_clear || ctl.emit_report)
        begin
            errors_next = '0;
        end
        else if (ctl.start_update && errors_reg != ERR_MAX)
        begin
            errors_next = errors_reg + 16'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.emit_pred || ctl.emit_report)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learning_rate_reg <= ETA_RESET;
            acc_reg           <= '0;
            pos_reg           <= '0;
            upd_idx_reg       <= '0;
            errors_reg        <= '0;
            out_valid_reg     <= 1'b0;
            for (int i = 0; i <= MAX_FEATURES; i++)
            begin
                weights_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
            begin
                learning_rate_reg <= cfg_data;
            end
            acc_reg       <= acc_next;
            pos_reg       <= pos_next;
            upd_idx_reg   <= upd_idx_next;
            errors_reg    <= errors_next;
            out_valid_reg <= out_valid_next;
            if (ctl.weights_clear)
            begin
                for (int i = 0; i <= MAX_FEATURES; i++)
                begin
                    weights_reg[i] <= '0;
                end
            end
            else
            begin
                if (ctl.weight_add)
                begin
                    weights_reg[w_rd_addr] <= sat32(w_sum);
                end
                if (ctl.bias_add)
                begin
                    weights_reg[0] <= sat32(b_sum);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg  <= kind_t'(kind);
            label_reg <= label;
            last_reg  <= last_feature;
        end
        if (ctl.buf_write)
        begin
            feature_buffer_reg[pos_reg[IDX_W-1:0]] <= feature_value;
        end
        if (ctl.emit_pred)
        begin
            pred_reg            <= pred_now;
            prediction_reg      <= pred_now;
            error_count_reg     <= '0;
            is_epoch_report_reg <= 1'b0;
        end
        else if (ctl.emit_report)
        begin
            prediction_reg      <= 1'b0;
            error_count_reg     <= errors_reg;
            is_epoch_report_reg <= 1'b1;
        end
    end

    assign out_valid       = out_valid_reg;
    assign prediction      = prediction_reg;
    assign error_count     = error_count_reg;
    assign is_epoch_report = is_epoch_report_reg;

endmodule

>>> tb/tb.sv
// tb: self-checking bench for perceptron_train_predict, directed cases then random traffic
// depends on ptp_pkg and the design sources; predicts each result from its own weight model
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptp_pkg::*;

    // settle time covers the longest item plus the output register
    localparam int SETTLE_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic        pred;
        logic [15:0] errs;
        logic        report;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    kind_t       kind = KIND_PREDICT;
    logic [15:0] feature_value = '0;
    logic        label = 1'b0;
    logic        last_feature = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        prediction;
    logic [15:0] error_count;
    logic        is_epoch_report;

    // weight model
    logic [15:0]        eta = ETA_RESET;
    logic signed [31:0] weight [0:MAX_FEATURES];
    logic signed [15:0] feat_buf [0:MAX_FEATURES-1];
    longint             net_sum = 0;
    int                 feat_pos = 0;
    logic [15:0]        miss_count = '0;

    outcome_t pending_outcomes [$];
    outcome_t want;
    bit       mismatch_seen = 1'b0;
    int       items_sent = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    int       idle_cycles = 0;

    perceptron_train_predict uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .kind            (kind),
        .feature_value   (feature_value),
        .label           (label),
        .last_feature    (last_feature),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .prediction      (prediction),
        .error_count     (error_count),
        .is_epoch_report (is_epoch_report)
    );

    always #5 clk = ~clk;

    initial
    begin
        for (int i = 0; i <= MAX_FEATURES; i++)
            weight[i] = '0;
    end

    function automatic logic signed [31:0] clip32(longint v);
        if (v > longint'(32'sh7FFFFFFF))
            return 32'sh7FFFFFFF;
        if (v < -longint'(32'sh7FFFFFFF) - 1)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // eta * x in Q8.24, rounded to Q8.16 with ties away from zero
    function automatic longint weight_step(logic signed [15:0] x);
        longint p;
        p = longint'(eta) * longint'(x);
        if (p >= 0)
            return (p + 128) / 256;
        return -((-p + 128) / 256);
    endfunction

    task automatic perceptron_accept(kind_t k, logic signed [15:0] x, logic lbl, logic lst);
        outcome_t o;
        longint   net;
        int       err_v;
        int       i;
        case (k)
            KIND_EPOCH:
            begin
                o.pred = 1'b0;
                o.errs = miss_count;
                o.report = 1'b1;
                pending_outcomes = {pending_outcomes, o};
                miss_count = '0;
            end
            KIND_CLEAR:
            begin
                for (i = 0; i <= MAX_FEATURES; i++)
                    weight[i] = '0;
                miss_count = '0;
                net_sum = 0;
                feat_pos = 0;
            end
            default:
            begin
                if (feat_pos < MAX_FEATURES)
                begin
                    feat_buf[feat_pos] = x;
                    net_sum += longint'(x) * longint'(weight[feat_pos + 1]);
                    feat_pos++;
                end
                if (lst)
                begin
                    net = longint'(weight[0]) * 256 + net_sum;
                    o.pred = (net > 0);
                    o.errs = '0;
                    o.report = 1'b0;
                    pending_outcomes = {pending_outcomes, o};
                    if (k == KIND_TRAIN)
                    begin
                        err_v = int'(lbl) - int'(o.pred);
                        if (err_v != 0 && eta != 0)
                        begin
                            for (i = 0; i < feat_pos; i++)
                                weight[i + 1] = clip32(longint'(weight[i + 1]) +
                                                       weight_step(feat_buf[i]) * err_v);
                            weight[0] = clip32(longint'(weight[0]) + longint'(eta) * err_v);
                            if (miss_count != ERR_MAX)
                                miss_count++;
                        end
                    end
                    net_sum = 0;
                    feat_pos = 0;
                end
            end
        endcase
    endtask

    // leaves in_valid high so a following item can go out without a gap
    task automatic send_item(kind_t k, logic [15:0] x, logic lbl, logic lst);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        feature_value <= x;
        label <= lbl;
        last_feature <= lst;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        perceptron_accept(k, x, lbl, lst);
        items_sent++;
    endtask

    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_eta(logic [15:0] v);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        eta = v;
    endtask

    function automatic logic [15:0] draw_feature();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3: return 16'($urandom_range(2047)) - 16'd1024;
            default: return 16'($urandom);
        endcase
    endfunction

    // one vector of n features; the closing kind decides, earlier kinds are sometimes mixed
    task automatic send_sample(kind_t close_kind, int n, bit close);
        kind_t fk;
        int    i;
        for (i = 0; i < n; i++)
        begin
            fk = close_kind;
            if ($urandom_range(7) == 0)
                fk = $urandom_range(1) ? KIND_TRAIN : KIND_PREDICT;
            if (i == n - 1 && close)
                send_item(close_kind, draw_feature(), 1'($urandom_range(1)), 1'b1);
            else
                send_item(fk, draw_feature(), 1'($urandom_range(1)), 1'b0);
        end
    endtask

    task automatic test_after_reset();
        send_item(KIND_EPOCH, 16'h0000, 1'b0, 1'b0);
        send_item(KIND_TRAIN, 16'h0100, 1'b1, 1'b1);
        send_item(KIND_PREDICT, 16'h0100, 1'b0, 1'b1);
        send_item(KIND_EPOCH, 16'h0000, 1'b0, 1'b0);
    endtask

    task automatic test_field_extremes();
        write_eta(16'hFFFF);
        send_item(KIND_TRAIN, 16'h7FFF, 1'b0, 1'b0);
        send_item(KIND_TRAIN, 16'h8000, 1'b1, 1'b1);
        send_item(KIND_TRAIN, 16'h8000, 1'b0, 1'b1);
    endtask

    task automatic test_zero_eta();
        write_eta(16'h0000);
        send_item(KIND_CLEAR, 16'hFFFF, 1'b1, 1'b1);
        send_item(KIND_TRAIN, 16'h0200, 1'b1, 1'b1);
        send_item(KIND_EPOCH, 16'hFFFF, 1'b1, 1'b1);
    endtask

    // predict features fill the buffer; the closing train item adds no feature
    task automatic test_feature_overflow();
        int i;
        write_eta(16'h0001);
        for (i = 0; i < MAX_FEATURES; i++)
            send_item(KIND_PREDICT, (i % 2) ? 16'h8000 : 16'h7FFF, 1'b0, 1'b0);
        send_item(KIND_TRAIN, 16'h1234, 1'b1, 1'b1);
    endtask

    task automatic test_mixed_kinds();
        write_eta(16'($urandom_range(1, 65535)));
        send_item(KIND_TRAIN, 16'h0400, 1'b1, 1'b0);
        send_item(KIND_PREDICT, 16'hFC00, 1'b1, 1'b1);
    endtask

    task automatic test_vector_interrupts();
        send_item(KIND_TRAIN, 16'h0300, 1'b0, 1'b0);
        send_item(KIND_EPOCH, 16'h5555, 1'b1, 1'b1);
        send_item(KIND_TRAIN, 16'hFD00, 1'b1, 1'b1);
        send_item(KIND_TRAIN, 16'h0300, 1'b0, 1'b0);
        send_item(KIND_CLEAR, 16'hAAAA, 1'b1, 1'b1);
        send_item(KIND_TRAIN, 16'h0280, 1'b1, 1'b1);
    endtask

    task automatic test_random_traffic(int send_pct, int stall_pct, logic [15:0] eta_val,
                                       int n_items);
        int    stop_at;
        int    pick;
        kind_t k;
        write_eta(eta_val);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            k = ($urandom_range(9) < 7) ? KIND_TRAIN : KIND_PREDICT;
            if (pick < 80)
                send_sample(k, ($urandom_range(9) == 0) ? $urandom_range(9, 11)
                                                         : $urandom_range(1, MAX_FEATURES), 1'b1);
            else if (pick < 88)
                send_item(KIND_EPOCH, draw_feature(), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            else if (pick < 90)
                send_item(KIND_CLEAR, draw_feature(), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            else if (pick < 95)
            begin
                // epoch close in the middle of a vector
                send_sample(k, $urandom_range(1, 3), 1'b0);
                send_item(KIND_EPOCH, draw_feature(), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
                send_sample(k, $urandom_range(1, 6), 1'b1);
            end
            else
            begin
                send_sample(k, $urandom_range(1, 5), 1'b0);
                send_item(KIND_CLEAR, draw_feature(), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end
        end
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: result with none pending: prediction %0d count %0d report %0d",
                         $time, prediction, error_count, is_epoch_report);
                mismatch_seen = 1'b1;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                if (prediction !== want.pred)
                begin
                    $display("%0t: prediction expected %0d got %0d", $time, want.pred,
                             prediction);
                    mismatch_seen = 1'b1;
                end
                if (error_count !== want.errs)
                begin
                    $display("%0t: error_count expected %0d got %0d", $time, want.errs,
                             error_count);
                    mismatch_seen = 1'b1;
                end
                if (is_epoch_report !== want.report)
                begin
                    $display("%0t: is_epoch_report expected %0d got %0d", $time, want.report,
                             is_epoch_report);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // cycles without any transfer on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_field_extremes();
        test_zero_eta();
        test_feature_overflow();
        test_mixed_kinds();
        test_vector_interrupts();
        test_random_traffic(0, 0, 16'($urandom_range(1, 65535)), 300);
        test_random_traffic(78, 0, 16'hFFFF, 300);
        test_random_traffic(0, 78, 16'($urandom_range(1, 300)), 300);
        test_random_traffic(31, 31, 16'h0000, 150);
        test_random_traffic(31, 31, 16'($urandom_range(1, 65535)), 250);
        test_random_traffic(0, 0, ETA_RESET, 120);
        wait_quiet();
        if (!mismatch_seen)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
